// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

	// built table size and field widths
	localparam int NUM_BUCKETS = 16;
	localparam int CAP_BITS    = 16;
	localparam int SLOT_W      = 4;
	localparam int AMT_W       = 16;
	localparam int SLOT_BITS   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int CNT_BITS    = $clog2(NUM_BUCKETS + 1);
	localparam int CMP_W       = (CAP_BITS > AMT_W) ? CAP_BITS : AMT_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int POLICY_W   = 2;
	localparam int COUNT_W    = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIT_POLICY   = 1'b0,
		REG_BUCKET_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [POLICY_W-1:0] {
		FP_FIRST = 2'd0,
		FP_BEST  = 2'd1,
		FP_WORST = 2'd2
	} fit_policy_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PLACE = 1'b1
	} op_code_t;

	// running choice held by the sequencer, seen by the compare unit
	typedef struct packed {
		logic                have;
		logic [CAP_BITS-1:0] best;
	} scan_state_t;

endpackage

// ===== rtl/bfa_cap_mem.sv =====
module bfa_cap_mem
	import bfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 we,
	input  logic [SLOT_BITS-1:0] wr_addr,
	input  logic [CAP_BITS-1:0]  wr_data,
	input  logic                 rd_en,
	input  logic [SLOT_BITS-1:0] rd_addr,
	output logic [CAP_BITS-1:0]  rd_data
);

	logic [CAP_BITS-1:0] mem_q [NUM_BUCKETS];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/bfa_fit_cmp.sv =====
module bfa_fit_cmp
	import bfa_pkg::*;
(
	input  fit_policy_t         policy,
	input  scan_state_t         cur,
	input  logic [CAP_BITS-1:0] cap,
	input  logic [AMT_W-1:0]    ball,
	output logic                take
);

	logic fits;
	logic below_best;

	// capacity must cover the ball
	assign fits       = CMP_W'(cap) >= CMP_W'(ball);
	assign below_best = cap < cur.best;

	// policy decides whether this bucket replaces the running pick
	always_comb begin
		case (policy)
			FP_FIRST: take = fits && !cur.have;
			FP_BEST:  take = fits && (!cur.have || below_best);
			FP_WORST: take = fits && (!cur.have || !below_best);
			default:  take = 1'b0;
		endcase
	end

endmodule

// ===== rtl/bin_fit_allocator.sv =====
// bucket allocator with first, best and worst fit placement
//
// item channel (item_valid / item_stall): op selects load or place. a load
// request writes amount into bucket bucket_slot in the accept cycle and
// produces no result. a place request scans buckets 0 .. bucket_count-1,
// capped at the 16 built buckets, one per cycle through the single read
// port of the capacity memory and a shared compare unit, then writes back
// the decremented capacity of the pick if a bucket fits. item_stall stays
// high from the accept of a place request until its write-back, so no new
// request is accepted while a place request is in progress; a load request
// does not stall the item channel.
// result channel (res_valid / res_stall): one result per place request,
// found and chosen_bucket (0 when nothing fits), held in an output register
// until taken. a new request is accepted while a result waits; a place
// request finishing while the old result is still stalled waits in its
// write-back step until the register frees.
// config channel (cfg_valid / cfg_ready, always ready): index 0 fit_policy,
// index 1 bucket_count; write only while idle.
// reset clears control state and sets first fit with 16 buckets; capacity
// memory is not cleared, each bucket must be loaded before it is scanned.
module bin_fit_allocator
	import bfa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  op,
	input  logic [SLOT_W-1:0]     bucket_slot,
	input  logic [AMT_W-1:0]      amount,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  found,
	output logic [SLOT_W-1:0]     chosen_bucket,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t               state_q;
	fit_policy_t          policy_q;
	logic [COUNT_W-1:0]   count_q;
	logic [CNT_BITS-1:0]  limit;
	logic [CNT_BITS-1:0]  issue_q;
	logic                 dvalid_s1;
	logic [SLOT_BITS-1:0] didx_s1;
	logic [AMT_W-1:0]     ball_q;
	scan_state_t          scan_q;
	logic [SLOT_BITS-1:0] pick_q;
	logic                 res_valid_q;
	logic                 found_q;
	logic [SLOT_W-1:0]    chosen_q;

	logic                 item_acc;
	logic                 load_we;
	logic                 rd_en;
	logic                 take;
	logic                 wb_go;
	logic                 mem_we;
	logic [SLOT_BITS-1:0] mem_waddr;
	logic [CAP_BITS-1:0]  mem_wdata;
	logic [CAP_BITS-1:0]  rd_data;

	// config registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= FP_FIRST;
			count_q  <= COUNT_W'(NUM_BUCKETS);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIT_POLICY:   policy_q <= fit_policy_t'(cfg_data[POLICY_W-1:0]);
				REG_BUCKET_COUNT: count_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// scan limit saturates at the built depth
	assign limit = (32'(count_q) > NUM_BUCKETS) ? CNT_BITS'(NUM_BUCKETS)
	                                             : CNT_BITS'(count_q);

	// handshake and control
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign load_we    = item_acc && (op == OP_LOAD)
	                    && (32'(bucket_slot) < NUM_BUCKETS);
	assign rd_en      = (state_q == ST_SCAN) && (issue_q < limit);
	assign wb_go      = (state_q == ST_WRITE) && (!res_valid_q || !res_stall);

	// memory write: load in idle or write-back of the pick
	assign mem_we    = load_we || (wb_go && scan_q.have);
	assign mem_waddr = load_we ? SLOT_BITS'(bucket_slot) : pick_q;
	assign mem_wdata = load_we ? CAP_BITS'(amount)
	                           : CAP_BITS'(CMP_W'(scan_q.best) - CMP_W'(ball_q));

	bfa_cap_mem u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (rd_en),
		.rd_addr (issue_q[SLOT_BITS-1:0]),
		.rd_data (rd_data)
	);

	bfa_fit_cmp u_cmp (
		.policy (policy_q),
		.cur    (scan_q),
		.cap    (rd_data),
		.ball   (ball_q),
		.take   (take)
	);

	// sequencer: issue reads, compare one bucket per cycle, write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= '0;
			dvalid_s1   <= 1'b0;
			didx_s1     <= '0;
			scan_q      <= '0;
			pick_q      <= '0;
			ball_q      <= '0;
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
			chosen_q    <= '0;
		end else begin
			if (res_valid_q && !res_stall && !wb_go) begin
				res_valid_q <= 1'b0;
			end
			dvalid_s1 <= rd_en;
			didx_s1   <= issue_q[SLOT_BITS-1:0];
			case (state_q)
				ST_IDLE: begin
					if (item_acc && (op == OP_PLACE)) begin
						state_q     <= ST_SCAN;
						issue_q     <= '0;
						ball_q      <= amount;
						scan_q.have <= 1'b0;
						scan_q.best <= '0;
						pick_q      <= '0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						issue_q <= issue_q + CNT_BITS'(1);
					end
					if (dvalid_s1 && take) begin
						scan_q.have <= 1'b1;
						scan_q.best <= rd_data;
						pick_q      <= didx_s1;
					end
					if (!rd_en && !dvalid_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (wb_go) begin
						res_valid_q <= 1'b1;
						found_q     <= scan_q.have;
						chosen_q    <= scan_q.have ? SLOT_W'(pick_q) : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign found         = found_q;
	assign chosen_bucket = chosen_q;

	// compare data only arrives while scanning
	a_dvalid_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		dvalid_s1 |-> state_q == ST_SCAN)
		else $error("read data returned outside scan");

	// memory is written only by a load in idle or by the write-back
	a_we_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_WRITE))
		else $error("capacity write during scan");

	// write-back always publishes a result
	a_wb_result: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> res_valid_q && state_q == ST_IDLE)
		else $error("write-back did not produce a result");

	// a miss reports bucket zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !found_q) |-> chosen_q == '0)
		else $error("not-found result with nonzero bucket");

endmodule
